@@ rtl/csd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants for the command string decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int KEY_W     = 40;
  localparam int BYTE_W    = 8;
  localparam int SEP_W     = 10;
  localparam int IDX_W     = 2;
  localparam int NUM_KREGS = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [SEP_W-1:0] SEP_MAX = 10'd1023;

  localparam int BUF_BYTES_DEF = 1024;
  localparam int KEY_LEN_DEF   = 5;
  localparam int NUM_KEYS_DEF  = 4;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP  = 3'd5;

  // "cmd_1" .. "cmd_4"
  localparam logic [KEY_W-1:0] KEY0_RST = 40'd427037056817;
  localparam logic [KEY_W-1:0] KEY1_RST = 40'd427037056818;
  localparam logic [KEY_W-1:0] KEY2_RST = 40'd427037056819;
  localparam logic [KEY_W-1:0] KEY3_RST = 40'd427037056820;
  localparam logic [BYTE_W-1:0] TERM_RST = 8'd120;
  localparam logic [BYTE_W-1:0] SEP_RST  = 8'd44;

  typedef struct packed {
    logic [NUM_KREGS-1:0][KEY_W-1:0] key_words;
    logic [BYTE_W-1:0]               term_char;
    logic [BYTE_W-1:0]               sep_char;
  } cfg_t;

  typedef struct packed {
    logic              key_matched;
    logic [IDX_W-1:0]  key_index;
    logic [SEP_W-1:0]  separator_count;
    logic              overflowed;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/csd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csd_cfg
// Configuration register file: key words, terminator and separator bytes.
// ----------------------------------------------------------------------------
module csd_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [csd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [csd_pkg::KEY_W-1:0]          cfg_data_i,
  output csd_pkg::cfg_t                           cfg_o
);

  csd_pkg::cfg_t cfg_q;
  csd_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        csd_pkg::REG_KEY0: cfg_d.key_words[0] = cfg_data_i;
        csd_pkg::REG_KEY1: cfg_d.key_words[1] = cfg_data_i;
        csd_pkg::REG_KEY2: cfg_d.key_words[2] = cfg_data_i;
        csd_pkg::REG_KEY3: cfg_d.key_words[3] = cfg_data_i;
        csd_pkg::REG_TERM: cfg_d.term_char    = cfg_data_i[csd_pkg::BYTE_W-1:0];
        csd_pkg::REG_SEP:  cfg_d.sep_char     = cfg_data_i[csd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_words[0] <= csd_pkg::KEY0_RST;
      cfg_q.key_words[1] <= csd_pkg::KEY1_RST;
      cfg_q.key_words[2] <= csd_pkg::KEY2_RST;
      cfg_q.key_words[3] <= csd_pkg::KEY3_RST;
      cfg_q.term_char    <= csd_pkg::TERM_RST;
      cfg_q.sep_char     <= csd_pkg::SEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/csd_content.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csd_content
// Takes one content byte into the command state: capacity check, separator
// count and first-field key matching.
// ----------------------------------------------------------------------------
module csd_content #(
  parameter int BUF_BYTES = csd_pkg::BUF_BYTES_DEF,
  parameter int KEY_LEN   = csd_pkg::KEY_LEN_DEF,
  parameter int NUM_KEYS  = csd_pkg::NUM_KEYS_DEF
) (
  input  wire logic                                       en_i,
  input  wire logic [csd_pkg::BYTE_W-1:0]                 byte_i,
  input  wire logic [csd_pkg::BYTE_W-1:0]                 sep_char_i,
  input  wire logic [NUM_KEYS-1:0][csd_pkg::KEY_W-1:0]    key_words_i,
  input  wire logic [$clog2(BUF_BYTES)-1:0]               stored_i,
  input  wire logic [csd_pkg::SEP_W-1:0]                  sep_total_i,
  input  wire logic                                       first_i,
  input  wire logic [$clog2(KEY_LEN+1)-1:0]               fpos_i,
  input  wire logic [NUM_KEYS-1:0]                        mask_i,
  input  wire logic                                       ovf_i,
  output logic      [$clog2(BUF_BYTES)-1:0]               stored_o,
  output logic      [csd_pkg::SEP_W-1:0]                  sep_total_o,
  output logic                                            first_o,
  output logic      [$clog2(KEY_LEN+1)-1:0]               fpos_o,
  output logic      [NUM_KEYS-1:0]                        mask_o,
  output logic                                            ovf_o
);

  localparam int CNT_W = $clog2(BUF_BYTES);
  localparam int FP_W  = $clog2(KEY_LEN+1);

  logic [5:0]                      shamt;
  logic [NUM_KEYS-1:0][63:0]       kw;
  logic [NUM_KEYS-1:0]             hit;

  // first character sits in the top used byte of the key word
  assign shamt = 6'(((KEY_LEN - 1) - int'(fpos_i)) * 8);

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      kw[k]  = 64'(key_words_i[k]) >> shamt;
      hit[k] = (kw[k][csd_pkg::BYTE_W-1:0] == byte_i);
    end
  end

  always_comb begin
    stored_o    = stored_i;
    sep_total_o = sep_total_i;
    first_o     = first_i;
    fpos_o      = fpos_i;
    mask_o      = mask_i;
    ovf_o       = ovf_i;
    if (en_i) begin
      if (stored_i >= CNT_W'(BUF_BYTES - 1)) begin
        ovf_o = 1'b1;
      end else begin
        stored_o = stored_i + CNT_W'(1);
        if (byte_i == sep_char_i) begin
          if (sep_total_i < csd_pkg::SEP_MAX) begin
            sep_total_o = sep_total_i + csd_pkg::SEP_W'(1);
          end
          first_o = 1'b0;
        end else if (first_i) begin
          if (fpos_i < FP_W'(KEY_LEN)) begin
            mask_o = mask_i & hit;
            fpos_o = fpos_i + FP_W'(1);
          end else begin
            mask_o = '0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/csd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csd_decode
// Per-byte next-state logic: terminator pairing, flushing of a lone
// terminator as content, and the result of a finished command.
// ----------------------------------------------------------------------------
module csd_decode #(
  parameter int BUF_BYTES = csd_pkg::BUF_BYTES_DEF,
  parameter int KEY_LEN   = csd_pkg::KEY_LEN_DEF,
  parameter int NUM_KEYS  = csd_pkg::NUM_KEYS_DEF
) (
  input  wire logic [csd_pkg::BYTE_W-1:0]                 byte_i,
  input  wire csd_pkg::cfg_t                              cfg_i,
  input  wire logic                                       pend_i,
  input  wire logic [$clog2(BUF_BYTES)-1:0]               stored_i,
  input  wire logic [csd_pkg::SEP_W-1:0]                  sep_total_i,
  input  wire logic                                       first_i,
  input  wire logic [$clog2(KEY_LEN+1)-1:0]               fpos_i,
  input  wire logic [NUM_KEYS-1:0]                        mask_i,
  input  wire logic                                       ovf_i,
  output logic                                            pend_o,
  output logic      [$clog2(BUF_BYTES)-1:0]               stored_o,
  output logic      [csd_pkg::SEP_W-1:0]                  sep_total_o,
  output logic                                            first_o,
  output logic      [$clog2(KEY_LEN+1)-1:0]               fpos_o,
  output logic      [NUM_KEYS-1:0]                        mask_o,
  output logic                                            ovf_o,
  output logic                                            res_valid_o,
  output csd_pkg::res_t                                   res_o
);

  localparam int CNT_W = $clog2(BUF_BYTES);
  localparam int FP_W  = $clog2(KEY_LEN+1);

  logic [NUM_KEYS-1:0][csd_pkg::KEY_W-1:0] keys;
  logic                  is_term;
  logic [CNT_W-1:0]      a_stored, b_stored;
  logic [csd_pkg::SEP_W-1:0] a_sep, b_sep;
  logic                  a_first, b_first;
  logic [FP_W-1:0]       a_fpos, b_fpos;
  logic [NUM_KEYS-1:0]   a_mask, b_mask;
  logic                  a_ovf, b_ovf;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      keys[k] = cfg_i.key_words[k];
    end
  end

  assign is_term = (byte_i == cfg_i.term_char);

  // a waiting lone terminator becomes content ahead of this byte
  csd_content #(
    .BUF_BYTES (BUF_BYTES),
    .KEY_LEN   (KEY_LEN),
    .NUM_KEYS  (NUM_KEYS)
  ) u_flush (
    .en_i        (pend_i & ~is_term),
    .byte_i      (cfg_i.term_char),
    .sep_char_i  (cfg_i.sep_char),
    .key_words_i (keys),
    .stored_i    (stored_i),
    .sep_total_i (sep_total_i),
    .first_i     (first_i),
    .fpos_i      (fpos_i),
    .mask_i      (mask_i),
    .ovf_i       (ovf_i),
    .stored_o    (a_stored),
    .sep_total_o (a_sep),
    .first_o     (a_first),
    .fpos_o      (a_fpos),
    .mask_o      (a_mask),
    .ovf_o       (a_ovf)
  );

  csd_content #(
    .BUF_BYTES (BUF_BYTES),
    .KEY_LEN   (KEY_LEN),
    .NUM_KEYS  (NUM_KEYS)
  ) u_take (
    .en_i        (~is_term),
    .byte_i      (byte_i),
    .sep_char_i  (cfg_i.sep_char),
    .key_words_i (keys),
    .stored_i    (a_stored),
    .sep_total_i (a_sep),
    .first_i     (a_first),
    .fpos_i      (a_fpos),
    .mask_i      (a_mask),
    .ovf_i       (a_ovf),
    .stored_o    (b_stored),
    .sep_total_o (b_sep),
    .first_o     (b_first),
    .fpos_o      (b_fpos),
    .mask_o      (b_mask),
    .ovf_o       (b_ovf)
  );

  always_comb begin
    res_o.key_matched     = 1'b0;
    res_o.key_index       = '0;
    res_o.separator_count = sep_total_i;
    res_o.overflowed      = ovf_i;
    if (fpos_i == FP_W'(KEY_LEN)) begin
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
        if (mask_i[k]) begin
          res_o.key_matched = 1'b1;
          res_o.key_index   = csd_pkg::IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    res_valid_o = is_term & pend_i;
    pend_o      = is_term & ~pend_i;
    stored_o    = b_stored;
    sep_total_o = b_sep;
    first_o     = b_first;
    fpos_o      = b_fpos;
    mask_o      = b_mask;
    ovf_o       = b_ovf;
    if (is_term & pend_i) begin
      stored_o    = '0;
      sep_total_o = '0;
      first_o     = 1'b1;
      fpos_o      = '0;
      mask_o      = '1;
      ovf_o       = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/command_string_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_string_decoder
// Splits a byte stream into commands ended by a doubled terminator byte and
// reports separator count, key match and overflow for each command.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while in_stall_o is low. A byte beat is
// captured in an input register and decoded against the command state once
// the output register is free, so a result beat reaches the output register
// from the input register after the second terminator byte is accepted; the
// output register lets the next byte be taken while a result is still held
// under stall. Config writes are taken every cycle (cfg_ready_o is tied high)
// and must happen while no byte is in flight. Content beyond BUF_BYTES-1
// bytes per command is dropped and sets overflowed_o.
// ----------------------------------------------------------------------------
module command_string_decoder #(
  parameter int BUF_BYTES = csd_pkg::BUF_BYTES_DEF,
  parameter int KEY_LEN   = csd_pkg::KEY_LEN_DEF,
  parameter int NUM_KEYS  = csd_pkg::NUM_KEYS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [csd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [csd_pkg::KEY_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [csd_pkg::BYTE_W-1:0]        data_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   key_matched_o,
  output logic      [csd_pkg::IDX_W-1:0]         key_index_o,
  output logic      [csd_pkg::SEP_W-1:0]         separator_count_o,
  output logic                                   overflowed_o
);

  localparam int CNT_W = $clog2(BUF_BYTES);
  localparam int FP_W  = $clog2(KEY_LEN+1);

  csd_pkg::cfg_t cfg;

  logic                      in_vld_q;
  logic [csd_pkg::BYTE_W-1:0] in_byte_q;

  logic                      pend_q, pend_d;
  logic [CNT_W-1:0]          stored_q, stored_d;
  logic [csd_pkg::SEP_W-1:0] sep_q, sep_d;
  logic                      first_q, first_d;
  logic [FP_W-1:0]           fpos_q, fpos_d;
  logic [NUM_KEYS-1:0]       mask_q, mask_d;
  logic                      ovf_q, ovf_d;

  logic                      res_valid;
  csd_pkg::res_t             res;
  logic                      out_vld_q;
  csd_pkg::res_t             out_q;

  logic                      out_free;
  logic                      proc;
  logic                      in_acc;

  csd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csd_decode #(
    .BUF_BYTES (BUF_BYTES),
    .KEY_LEN   (KEY_LEN),
    .NUM_KEYS  (NUM_KEYS)
  ) u_decode (
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .pend_i      (pend_q),
    .stored_i    (stored_q),
    .sep_total_i (sep_q),
    .first_i     (first_q),
    .fpos_i      (fpos_q),
    .mask_i      (mask_q),
    .ovf_i       (ovf_q),
    .pend_o      (pend_d),
    .stored_o    (stored_d),
    .sep_total_o (sep_d),
    .first_o     (first_d),
    .fpos_o      (fpos_d),
    .mask_o      (mask_d),
    .ovf_o       (ovf_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign proc       = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign out_valid_o       = out_vld_q;
  assign key_matched_o     = out_q.key_matched;
  assign key_index_o       = out_q.key_index;
  assign separator_count_o = out_q.separator_count;
  assign overflowed_o      = out_q.overflowed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      stored_q  <= '0;
      sep_q     <= '0;
      first_q   <= 1'b1;
      fpos_q    <= '0;
      mask_q    <= '1;
      ovf_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        pend_q   <= pend_d;
        stored_q <= stored_d;
        sep_q    <= sep_d;
        first_q  <= first_d;
        fpos_q   <= fpos_d;
        mask_q   <= mask_d;
        ovf_q    <= ovf_d;
      end
      if (proc & res_valid) begin
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= data_byte_i;
    end
    if (proc & res_valid) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/csd_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_scoreboard_pkg
// Command tracker for the command string decoder testbench: follows the byte
// stream beat by beat, predicts one report per finished command and checks
// the reports that leave the block in order.
// ----------------------------------------------------------------------------
package csd_scoreboard_pkg;
  import csd_pkg::*;

  localparam int BUF_BYTES = BUF_BYTES_DEF;
  localparam int KEY_LEN   = KEY_LEN_DEF;
  localparam int NUM_KEYS  = NUM_KEYS_DEF;

  class command_scoreboard;
    logic [KEY_W-1:0]    key_words [NUM_KREGS];
    logic [BYTE_W-1:0]   term_char;
    logic [BYTE_W-1:0]   sep_char;
    logic                term_waiting;
    int                  stored_bytes;
    logic [SEP_W-1:0]    sep_total;
    logic                in_first_field;
    int                  field_pos;
    logic [NUM_KEYS-1:0] candidates;
    logic                overflow_seen;
    res_t                awaited [$];
    int unsigned         errors;

    function new();
      key_words[0] = KEY0_RST;
      key_words[1] = KEY1_RST;
      key_words[2] = KEY2_RST;
      key_words[3] = KEY3_RST;
      term_char    = TERM_RST;
      sep_char     = SEP_RST;
      term_waiting = 1'b0;
      errors       = 0;
      start_command();
    endfunction

    function void start_command();
      stored_bytes   = 0;
      sep_total      = '0;
      in_first_field = 1'b1;
      field_pos      = 0;
      candidates     = '1;
      overflow_seen  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_words[idx] = value;
        REG_TERM: term_char = value[BYTE_W-1:0];
        REG_SEP:  sep_char  = value[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function void store_content(logic [BYTE_W-1:0] b);
      if (stored_bytes >= BUF_BYTES - 1) begin
        overflow_seen = 1'b1;
        return;
      end
      stored_bytes++;
      if (b == sep_char) begin
        if (sep_total < SEP_MAX) sep_total++;
        in_first_field = 1'b0;
      end else if (in_first_field) begin
        if (field_pos < KEY_LEN) begin
          for (int k = 0; k < NUM_KEYS; k++)
            if (key_words[k][8*(KEY_LEN-1-field_pos) +: 8] != b) candidates[k] = 1'b0;
          field_pos++;
        end else begin
          candidates = '0;
        end
      end
    endfunction

    // called for every accepted input beat
    function void take_byte(logic [BYTE_W-1:0] b);
      res_t r;
      if (b == term_char) begin
        if (!term_waiting) begin
          term_waiting = 1'b1;
          return;
        end
        term_waiting = 1'b0;
        r = '0;
        if (field_pos == KEY_LEN)
          for (int k = NUM_KEYS - 1; k >= 0; k--)
            if (candidates[k]) begin
              r.key_matched = 1'b1;
              r.key_index   = IDX_W'(k);
            end
        r.separator_count = sep_total;
        r.overflowed      = overflow_seen;
        awaited.push_back(r);
        start_command();
        return;
      end
      if (term_waiting) begin
        term_waiting = 1'b0;
        store_content(term_char);
      end
      store_content(b);
    endfunction

    // called for every accepted result beat
    function void check_report(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got matched=%0d index=%0d seps=%0d ovf=%0d",
                 $time, got.key_matched, got.key_index, got.separator_count, got.overflowed);
        return;
      end
      want = awaited.pop_front();
      if (got.key_matched !== want.key_matched || got.key_index !== want.key_index ||
          got.separator_count !== want.separator_count || got.overflowed !== want.overflowed) begin
        errors++;
        $display("%0t: report mismatch, expected matched=%0d index=%0d seps=%0d ovf=%0d, got matched=%0d index=%0d seps=%0d ovf=%0d",
                 $time, want.key_matched, want.key_index, want.separator_count, want.overflowed,
                 got.key_matched, got.key_index, got.separator_count, got.overflowed);
      end
    endfunction
  endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for command_string_decoder: directed commands for terminator,
// separator, key and capacity corners, then random commands under several
// register settings with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import csd_pkg::*;
  import csd_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BYTES = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [KEY_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    data_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 key_matched_o;
  logic [IDX_W-1:0]     key_index_o;
  logic [SEP_W-1:0]     separator_count_o;
  logic                 overflowed_o;

  command_scoreboard sb;
  int unsigned       bytes_sent = 0;
  int unsigned       cycles = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  bit                hold_request = 1'b0;

  command_string_decoder #(
    .BUF_BYTES(BUF_BYTES),
    .KEY_LEN  (KEY_LEN),
    .NUM_KEYS (NUM_KEYS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_matched_o    (key_matched_o),
    .key_index_o      (key_index_o),
    .separator_count_o(separator_count_o),
    .overflowed_o     (overflowed_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("command_string_decoder regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o && !out_stall_i)
        sb.check_report('{key_matched_o, key_index_o, separator_count_o, overflowed_o});
      if (in_valid_i && !in_stall_o) sb.take_byte(data_byte_i);
    end
  end

  // result side: random stall per beat, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // let every report come back, then let any byte still in flight settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [KEY_W-1:0] k0, k1, k2, k3,
                              input logic [BYTE_W-1:0] term, sep);
    logic [CFG_IDX_W-1:0] regs [6] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
                                        REG_TERM, REG_SEP};
    logic [KEY_W-1:0]     vals [6];
    vals = '{k0, k1, k2, k3, {$urandom(), term}, {$urandom(), sep}};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key(input logic [BYTE_W-1:0] term, sep);
    logic [KEY_W-1:0]  k;
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < KEY_LEN; i++) begin
      do b = BYTE_W'($urandom_range(0, 255)); while (b == term || b == sep);
      k[8*i +: 8] = b;
    end
    return k;
  endfunction

  function automatic logic [BYTE_W-1:0] content_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == sb.term_char);
    return b;
  endfunction

  // one command built around a key: exact, flipped bit, cut short, too long,
  // random or empty first field; then a few fields, maybe a lone terminator
  task automatic send_command();
    logic [BYTE_W-1:0] cmd [$];
    logic [KEY_W-1:0]  key;
    int unsigned       shape;
    key   = sb.key_words[$urandom_range(0, NUM_KREGS - 1)];
    shape = $urandom_range(0, 9);
    if (shape <= 7)
      for (int i = KEY_LEN - 1; i >= 0; i--) cmd.push_back(key[8*i +: 8]);
    if (shape == 5)
      cmd[$urandom_range(0, KEY_LEN - 1)] ^= BYTE_W'(1 << $urandom_range(0, 7));
    if (shape == 6) repeat ($urandom_range(1, KEY_LEN)) void'(cmd.pop_back());
    if (shape == 7) cmd.push_back(content_byte());
    if (shape == 8) repeat ($urandom_range(0, 7)) cmd.push_back(content_byte());
    repeat ($urandom_range(0, 3)) begin
      cmd.push_back(sb.sep_char);
      if (sb.sep_char == sb.term_char) cmd.push_back(content_byte());
      repeat ($urandom_range(0, 4)) cmd.push_back(content_byte());
    end
    if ($urandom_range(0, 5) == 0) begin
      cmd.push_back(sb.term_char);
      cmd.push_back(content_byte());
    end
    cmd.push_back(sb.term_char);
    cmd.push_back(sb.term_char);
    if ($urandom_range(0, 7) == 0) cmd.push_back(sb.term_char);
    foreach (cmd[i]) send_byte(cmd[i]);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
      else
        send_command();
    end
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0]  k;
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] s;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KEY0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: key hits, triple terminator, zero and all-ones bytes,
    // empty command, lone terminator as content
    send_text("cmd_1,,xx");
    send_text("cmd_4xxx");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("xx");
    send_text("xx");
    send_text("cmdx_1xx");
    // capacity: separators past the buffer are dropped
    repeat (BUF_BYTES + 1) send_byte(SEP_RST);
    send_text("xqxx");
    drain();

    // register extremes, duplicate keys: lowest index wins
    write_config('0, '0, '1, rand_key(8'hFF, 8'hFE), 8'hFF, 8'hFE);
    repeat (KEY_LEN) send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    random_traffic(PHASE_BYTES);
    drain();

    write_config(rand_key(8'h00, 8'h01), '1, '1, '0, 8'h00, 8'h01);
    repeat (KEY_LEN) send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    random_traffic(PHASE_BYTES);
    drain();

    // separator equal to terminator
    t = BYTE_W'($urandom_range(0, 255));
    write_config(rand_key(t, t), rand_key(t, t), rand_key(t, t), rand_key(t, t), t, t);
    random_traffic(PHASE_BYTES);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      t = BYTE_W'($urandom_range(0, 255));
      do s = BYTE_W'($urandom_range(0, 255)); while (s == t);
      k = rand_key(t, s);
      if (phase == 0)
        write_config(k, k, k, k, t, s);
      else
        write_config(rand_key(t, s), rand_key(t, s), k, k, t, s);
      if (phase == 1) begin
        // output held off while the input keeps coming at full rate
        hold_request = 1'b1;
        tx_calm      = 1'b1;
        random_traffic(80);
        tx_calm      = 1'b0;
      end else begin
        random_traffic(PHASE_BYTES);
      end
      drain();
    end

    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0)
      $display("command_string_decoder regression: pass");
    else
      $display("command_string_decoder regression: fail");
    $finish;
  end

endmodule
